// ===== rtl/core/hhe_pkg.sv =====
// Shared types and constants for the HTTP Host header extractor.
`timescale 1ns / 1ps

package hhe_pkg;

    localparam int NUM_METHODS = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int HCNT_W      = 11;
    localparam int OUT_DATA_W  = 24;

    // Parse phase codes
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_HOST   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // Result kinds (tuser)
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] HOST_PAT_LEN = 3'd7;
    // First character in the top byte
    localparam logic [55:0] HOST_PAT = "\nHost: ";

    // Method words padded to 8 characters, first character in the top byte.
    // Index 0 is GET, 6 is CONNECT.
    localparam logic [NUM_METHODS-1:0][63:0] METHOD_WORDS = {
        "CONNECT ", "DELETE  ", "PUT     ", "HEAD    ",
        "OPTIONS ", "POST    ", "GET     "
    };
    localparam logic [NUM_METHODS-1:0][3:0] METHOD_LENS = {
        4'd8, 4'd7, 4'd4, 4'd5, 4'd8, 4'd5, 4'd4
    };

    typedef struct packed {
        logic              has_char;
        logic [7:0]        host_char;
        logic              has_verdict;
        logic              is_http;
        logic              host_found;
        logic [HCNT_W-1:0] host_length;
    } t_entry;

    function automatic logic [7:0] method_byte(input logic [2:0] idx, input logic [2:0] pos);
        logic [63:0] word;
        word = METHOD_WORDS[idx];
        return word[{~pos, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] host_pat_byte(input logic [2:0] pos);
        logic [2:0] off;
        off = 3'd6 - pos;
        return HOST_PAT[{off, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/core/hhe_front.sv =====
// Front end: per-byte method check, Host line search and host byte classification.
`timescale 1ns / 1ps

module hhe_front #(
    parameter logic [10:0] HOST_CAP = 11'd2047
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_eop,
    output logic           o_push,
    output hhe_pkg::t_entry o_entry
);
    import hhe_pkg::*;

    logic [3:0]             r_prefix_count, n_prefix_count;
    logic [NUM_METHODS-1:0] r_cand, n_cand;
    logic [2:0]             r_pat_pos, n_pat_pos;
    logic [1:0]             r_phase, n_phase;
    logic                   r_port_seen, n_port_seen;
    logic [HCNT_W-1:0]      r_host_count, n_host_count;
    logic                   r_str_end, n_str_end;

    logic       active;
    logic       emit;
    logic [2:0] pat_inc;

    always_comb begin
        n_str_end      = r_str_end | (i_byte == CH_NUL);
        active         = !n_str_end;
        n_prefix_count = r_prefix_count;
        n_cand         = r_cand;
        n_pat_pos      = r_pat_pos;
        n_phase        = r_phase;
        n_port_seen    = r_port_seen;
        n_host_count   = r_host_count;
        emit           = 1'b0;
        pat_inc        = 3'd0;

        if (active && r_prefix_count < 4'd8) begin
            for (int i = 0; i < NUM_METHODS; i++) begin
                if (r_prefix_count < METHOD_LENS[i] &&
                    method_byte(3'(i), r_prefix_count[2:0]) != i_byte) begin
                    n_cand[i] = 1'b0;
                end
            end
            n_prefix_count = r_prefix_count + 4'd1;
        end

        if (active) begin
            case (r_phase)
                PH_SEARCH: begin
                    if (r_pat_pos < HOST_PAT_LEN && host_pat_byte(r_pat_pos) == i_byte) begin
                        pat_inc = r_pat_pos + 3'd1;
                    end else begin
                        pat_inc = (i_byte == CH_LF) ? 3'd1 : 3'd0;
                    end
                    if (pat_inc == HOST_PAT_LEN) begin
                        n_phase   = PH_HOST;
                        n_pat_pos = 3'd0;
                    end else begin
                        n_pat_pos = pat_inc;
                    end
                end
                PH_HOST: begin
                    if (i_byte == CH_CR) begin
                        n_phase = PH_DONE;
                    end else if (!r_port_seen) begin
                        if (i_byte == CH_COLON) begin
                            n_port_seen = 1'b1;
                        end else begin
                            emit = 1'b1;
                            if (r_host_count < HOST_CAP) begin
                                n_host_count = r_host_count + 11'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_entry.has_char    = emit;
        o_entry.host_char   = i_byte;
        o_entry.has_verdict = i_eop;
        o_entry.is_http     = (n_prefix_count >= 4'd8) && (|n_cand);
        o_entry.host_found  = (n_phase == PH_DONE);
        o_entry.host_length = (n_phase == PH_DONE) ? n_host_count : '0;
        o_push              = i_accept && (emit || i_eop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_eop)) begin
            // return to the idle parse state on reset and after each verdict
            r_prefix_count <= '0;
            r_cand         <= '1;
            r_pat_pos      <= '0;
            r_phase        <= PH_SEARCH;
            r_port_seen    <= 1'b0;
            r_host_count   <= '0;
            r_str_end      <= 1'b0;
        end else if (i_accept) begin
            r_prefix_count <= n_prefix_count;
            r_cand         <= n_cand;
            r_pat_pos      <= n_pat_pos;
            r_phase        <= n_phase;
            r_port_seen    <= n_port_seen;
            r_host_count   <= n_host_count;
            r_str_end      <= n_str_end;
        end
    end

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_host_count <= HOST_CAP)
        else $error("host count above cap");

    a_reset_after_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_eop |=> r_prefix_count == 4'd0 && r_phase == PH_SEARCH
                              && r_host_count == '0 && !r_str_end)
        else $error("parse state not cleared after verdict");

endmodule

// ===== rtl/core/hhe_queue.sv =====
// Short register queue of classified entries between front and back end.
`timescale 1ns / 1ps

module hhe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hhe_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output hhe_pkg::t_entry o_head
);
    import hhe_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W + 1)'(QUEUE_DEPTH) && !(i_push && o_full))
        else $error("queue overflow");

endmodule

// ===== rtl/core/hhe_back.sv =====
// Back end: turns queue entries into host byte beats and verdict beats.
`timescale 1ns / 1ps

module hhe_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  hhe_pkg::t_entry                i_head,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [hhe_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                           o_tuser,
    output logic                           o_tlast
);
    import hhe_pkg::*;

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data, n_data;
    logic                  r_kind, n_kind;
    logic                  r_last, n_last;
    logic                  r_char_sent, n_char_sent;
    logic                  load;

    assign load = !i_empty && (!r_valid || i_tready);

    always_comb begin
        n_char_sent = r_char_sent;
        o_pop       = 1'b0;
        if (i_head.has_char && !r_char_sent) begin
            n_kind = KIND_CHAR;
            n_data = {13'd0, 3'd0, i_head.host_char};
            n_last = !i_head.has_verdict;
            if (i_head.has_verdict) begin
                // hold the entry for its verdict beat
                n_char_sent = 1'b1;
            end else begin
                o_pop = load;
            end
        end else begin
            n_kind      = KIND_VERDICT;
            n_data      = {3'd0, i_head.host_length, i_head.host_found, i_head.is_http, 8'd0};
            n_last      = 1'b1;
            n_char_sent = 1'b0;
            o_pop       = load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_char_sent <= 1'b0;
        end else if (load) begin
            r_valid     <= 1'b1;
            r_char_sent <= n_char_sent;
        end else if (i_tready) begin
            r_valid     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
            r_kind <= n_kind;
            r_last <= n_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_VERDICT |-> r_last)
        else $error("verdict beat without last");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_CHAR |-> r_data[OUT_DATA_W-1:8] == '0)
        else $error("host byte beat carries verdict bits");

    a_split_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_sent |-> r_valid && r_kind == KIND_CHAR && !r_last)
        else $error("pending verdict without its host byte beat");

endmodule

// ===== rtl/core/http_host_header_extractor.sv =====
// Top level: HTTP Host header extractor with decoupled parser and result stage.
// Results are registered in the 4-entry queue between the stages and in the output stage.
// Throughput: one payload beat per cycle unless the queue is full; a beat causing both
// a host byte and the verdict takes two output beats, absorbed by that queue.
// Reset (synchronous, active low) clears the parse state, the queue and the output stage.
`timescale 1ns / 1ps

module http_host_header_extractor #(
    parameter int LENGTH_LIMIT = 2047
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                           i_s_axis_tlast,  // end_of_packet
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] host_char, [8] is_http_request, [9] host_found, [20:10] host_length
    output logic [hhe_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tuser,  // [0] result_kind
    output logic                           o_m_axis_tlast   // last_of_run
);
    import hhe_pkg::*;

    localparam logic [HCNT_W-1:0] HOST_CAP =
        (LENGTH_LIMIT < 2047) ? HCNT_W'(LENGTH_LIMIT) : 11'd2047;

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry entry;
    t_entry head;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    hhe_front #(
        .HOST_CAP (HOST_CAP)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_eop    (i_s_axis_tlast),
        .o_push   (push),
        .o_entry  (entry)
    );

    hhe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    hhe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the HTTP Host header extractor: packets in, results out.
`timescale 1ns / 1ps

module tb_top;
    import hhe_pkg::*;

    localparam int LENGTH_LIMIT = 2047;
    localparam int HOST_CAP     = (LENGTH_LIMIT < 2047) ? LENGTH_LIMIT : 2047;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int BIG_HOST     = 2060;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam int TIMEOUT_NS   = 2000000;

    typedef struct packed {
        logic              kind;
        logic [7:0]        ch;
        logic              http;
        logic              found;
        logic [HCNT_W-1:0] len;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [7:0] b;
        logic       eop;
        logic       typed;
        t_result    verdict;
    } t_dir_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data = '0;
    logic                  s_last = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // parser state mirrored from the block
    logic [3:0]             pfx_cnt;
    logic [NUM_METHODS-1:0] method_alive;
    logic [2:0]             tag_pos;
    logic [1:0]             phase;
    logic                   in_port;
    logic [HCNT_W-1:0]      host_len;
    logic                   nul_seen;

    t_result    pending_results[$];
    t_dir_row   dir_tab[$];
    logic [7:0] pkt[$];
    string      method_word[NUM_METHODS];
    string      host_tag;
    int         idle_s = 0;
    int         idle_r = 0;
    int         hold_asks = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         mismatch_cnt = 0;

    http_host_header_extractor #(
        .LENGTH_LIMIT(LENGTH_LIMIT)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    task automatic clear_parse_state();
        pfx_cnt      = '0;
        method_alive = '1;
        tag_pos      = '0;
        phase        = PH_SEARCH;
        in_port      = 1'b0;
        host_len     = '0;
        nul_seen     = 1'b0;
    endtask

    // Advance the mirrored parser by one payload beat and queue what it emits.
    task automatic parse_payload_byte(input logic [7:0] b, input logic eop,
                                      input logic typed, input t_result typed_verdict);
        t_result r;
        int      m;
        string   w;
        logic    emit_char;
        emit_char = 1'b0;
        if (!nul_seen && b == CH_NUL)
            nul_seen = 1'b1;
        if (!nul_seen) begin
            if (pfx_cnt < 8) begin
                for (m = 0; m < NUM_METHODS; m++) begin
                    w = method_word[m];
                    if (pfx_cnt < w.len() && w[pfx_cnt] != b)
                        method_alive[m] = 1'b0;
                end
                pfx_cnt = pfx_cnt + 4'd1;
            end
            case (phase)
                PH_SEARCH: begin
                    if (tag_pos < host_tag.len() && host_tag[tag_pos] == b)
                        tag_pos = tag_pos + 3'd1;
                    else
                        tag_pos = (b == CH_LF) ? 3'd1 : 3'd0;
                    if (tag_pos == host_tag.len()) begin
                        phase   = PH_HOST;
                        tag_pos = '0;
                    end
                end
                PH_HOST: begin
                    if (b == CH_CR) begin
                        phase = PH_DONE;
                    end else if (!in_port) begin
                        if (b == CH_COLON) begin
                            in_port = 1'b1;
                        end else begin
                            emit_char = 1'b1;
                            if (host_len < HOST_CAP)
                                host_len = host_len + HCNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (emit_char) begin
            r      = '0;
            r.kind = KIND_CHAR;
            r.ch   = b;
            r.last = !eop;
            pending_results.push_back(r);
        end
        if (eop) begin
            r       = '0;
            r.kind  = KIND_VERDICT;
            r.http  = (pfx_cnt >= 8) && (method_alive != '0);
            r.found = (phase == PH_DONE);
            r.len   = r.found ? host_len : '0;
            r.last  = 1'b1;
            pending_results.push_back(typed ? typed_verdict : r);
            clear_parse_state();
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic eop, input logic typed,
                           input logic http, input logic found, input int len);
        t_dir_row row;
        row               = '0;
        row.b             = b;
        row.eop           = eop;
        row.typed         = typed;
        row.verdict.kind  = KIND_VERDICT;
        row.verdict.http  = http;
        row.verdict.found = found;
        row.verdict.len   = HCNT_W'(len);
        row.verdict.last  = 1'b1;
        dir_tab.push_back(row);
    endtask

    // Present one beat, hold it until accepted, then predict.
    task automatic send_beat(input logic [7:0] b, input logic eop,
                             input logic typed, input t_result typed_verdict);
        while ($urandom_range(99) < idle_s) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eop;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        @(negedge clk);
        parse_payload_byte(b, eop, typed, typed_verdict);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            pkt.push_back(s[i]);
    endtask

    // Build one packet; host_bytes >= 0 forces a clean request with that host length.
    task automatic build_packet(input int host_bytes);
        int         sel;
        int         n;
        int         k;
        int         i;
        logic [7:0] c;
        pkt.delete();
        sel = (host_bytes >= 0) ? 99 : $urandom_range(99);
        if (sel < 8) begin
            // noise of any byte value
            n = $urandom_range(1, 24);
            repeat (n) pkt.push_back(8'($urandom_range(255)));
            return;
        end
        push_text(method_word[$urandom_range(NUM_METHODS - 1)]);
        if (sel < 18) begin
            // near miss: flip one bit of the method word
            k      = $urandom_range(pkt.size() - 1);
            pkt[k] = pkt[k] ^ (8'h01 << $urandom_range(7));
        end
        push_text("/");
        repeat ($urandom_range(4)) begin
            c = 8'($urandom_range(25));
            pkt.push_back(c + "a");
        end
        push_text(" HTTP/1.1\r");
        if (host_bytes < 0 && $urandom_range(3) == 0)
            push_text("\nAccept: */*\r");
        k = (host_bytes >= 0) ? 0 : $urandom_range(9);
        if (k == 7 || k == 8) begin
            // partial tag, either broken off or restarted by a full one
            n = $urandom_range(1, host_tag.len() - 1);
            for (i = 0; i < n; i++)
                pkt.push_back(host_tag[i]);
            if (k == 7)
                push_text("x");
        end
        if (k != 7 && k != 9) begin
            push_text(host_tag);
            if (host_bytes >= 0)
                n = host_bytes;
            else
                n = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(10);
            repeat (n) begin
                if ($urandom_range(9) == 0) begin
                    c = 8'($urandom_range(1, 255));
                    while (c == CH_COLON || c == CH_CR)
                        c = 8'($urandom_range(1, 255));
                end else begin
                    c = 8'($urandom_range(25));
                    c = ($urandom_range(7) == 0) ? "." : c + "a";
                end
                pkt.push_back(c);
            end
            if (host_bytes < 0 && $urandom_range(3) == 0) begin
                push_text(":");
                repeat ($urandom_range(5)) begin
                    c = 8'($urandom_range(9));
                    pkt.push_back(($urandom_range(7) == 0) ? CH_COLON : c + "0");
                end
            end
            if (host_bytes >= 0 || $urandom_range(6) != 0)
                push_text("\r\n");
        end
        if (host_bytes < 0) begin
            if ($urandom_range(9) == 0) begin
                push_text(host_tag);
                push_text("dup\r");
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom_range(255)));
            if ($urandom_range(11) == 0)
                pkt[$urandom_range(pkt.size() - 1)] = CH_NUL;
            if ($urandom_range(11) == 0) begin
                n = $urandom_range(1, pkt.size());
                while (pkt.size() > n)
                    void'(pkt.pop_back());
            end
        end
    endtask

    task automatic send_packet(inout int sent);
        t_result none;
        int      i;
        none = '0;
        for (i = 0; i < pkt.size(); i++)
            send_beat(pkt[i], i == pkt.size() - 1, 1'b0, none);
        sent += pkt.size();
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // Receiver: random backpressure, or a counted hold-off when asked.
    always @(negedge clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_r);
        end
    end

    always @(posedge clk) begin : out_check
        t_result want;
        logic    ok;
        if (rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected result beat: tdata=%06h tuser=%0d tlast=%0d",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = pending_results.pop_front();
                ok = (m_tuser === want.kind) && (m_tdata[7:0] === want.ch)
                    && (m_tdata[8] === want.http) && (m_tdata[9] === want.found)
                    && (m_tdata[20:10] === want.len)
                    && (m_tdata[OUT_DATA_W-1:21] === '0) && (m_tlast === want.last);
                if (!ok) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX) begin
                        $display("mismatch: exp kind=%0d ch=%02h http=%0d found=%0d len=%0d last=%0d",
                                 want.kind, want.ch, want.http, want.found, want.len,
                                 want.last);
                        $display("          got kind=%0d ch=%02h http=%0d found=%0d len=%0d last=%0d pad=%0h",
                                 m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9],
                                 m_tdata[20:10], m_tlast, m_tdata[OUT_DATA_W-1:21]);
                    end
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        string s;
        int    i;
        int    ph;
        int    sent;
        logic  paused;
        method_word[0] = "GET ";
        method_word[1] = "POST ";
        method_word[2] = "OPTIONS ";
        method_word[3] = "HEAD ";
        method_word[4] = "PUT ";
        method_word[5] = "DELETE ";
        method_word[6] = "CONNECT ";
        host_tag       = "\nHost: ";
        sent           = 0;
        clear_parse_state();

        // directed rows: byte, last, typed verdict (http, found, length)
        add_row(CH_NUL, 1'b1, 1'b1, 1'b0, 1'b0, 0);    // lone zero byte
        add_row(8'hFF,  1'b1, 1'b1, 1'b0, 1'b0, 0);
        add_row("G",    1'b0, 1'b0, 1'b0, 1'b0, 0);
        add_row(CH_NUL, 1'b0, 1'b0, 1'b0, 1'b0, 0);
        add_row("E",    1'b1, 1'b1, 1'b0, 1'b0, 0);    // flag after the string ended
        s = "GET \nHost: ab:9";
        for (i = 0; i < s.len(); i++)
            add_row(s[i], 1'b0, 1'b0, 1'b0, 1'b0, 0);
        add_row(CH_CR,  1'b1, 1'b1, 1'b1, 1'b1, 2);    // port dropped, length 2

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < dir_tab.size(); i++)
            send_beat(dir_tab[i].b, dir_tab[i].eop, dir_tab[i].typed, dir_tab[i].verdict);
        pause_until_drained();

        for (ph = 0; ph < 3; ph++) begin
            idle_s = (ph == 0) ? 32 : (ph == 1) ? 88 : 0;
            idle_r = (ph == 0) ? 88 : (ph == 1) ? 32 : 0;
            if (ph == 2) begin
                // stall the output while the input keeps streaming
                hold_asks = hold_asks + 1;
                build_packet(BIG_HOST);
                send_packet(sent);
            end
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                build_packet(-1);
                send_packet(sent);
                if (!paused && sent >= PHASE_ITEMS / 2) begin
                    pause_until_drained();
                    paused = 1'b1;
                end
            end
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
